/* design/ctes_pkg.sv */
// Shared types and constants for the civil-time to epoch-seconds converter.
// No dependencies; used by ctes_pipe_ctrl and civil_time_to_epoch_seconds_top.
package ctes_pkg;

  // Field widths
  localparam int unsigned YearOffW = 13;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecondW  = 6;
  localparam int unsigned SecsW    = 38;

  // Internal widths
  localparam int unsigned YearW    = 14;  // full calendar year, up to 10091
  localparam int unsigned RelYearW = 13;  // years since 1970, up to 8121
  localparam int unsigned CentW    = 7;   // year / 100, up to 100
  localparam int unsigned Quart4W  = YearW - 2;
  localparam int unsigned LeapW    = 12;  // leap days since 1970
  localparam int unsigned YearDayW = 22;  // 365 * years since 1970
  localparam int unsigned MdayW    = 9;   // day within the year, up to 366

  // Calendar constants
  localparam int unsigned YearBase      = 1900;
  localparam int unsigned EpochYear     = 1970;
  localparam int unsigned EpochYearOff  = EpochYear - YearBase;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned SixtyPer      = 60;
  // leaps_before(1970) = 1969/4 - 1969/100 + 1969/400
  localparam int unsigned EpochLeaps    = 1969 / 4 - 1969 / 100 + 1969 / 400;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned FebIndex      = 1;

  // Reciprocal of 100: exact floor for any operand below 2^15
  localparam int unsigned RecipShift = 20;
  localparam int unsigned Recip100W  = 14;
  localparam int unsigned Recip100   = ((1 << RecipShift) + 99) / 100;
  localparam int unsigned ProdW      = YearW + Recip100W;

  // Pipeline depth
  localparam int unsigned NumStages = 7;

  // Stage load enables and occupancy
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

  // Days in the year before the first of each month (common year)
  function automatic logic [MdayW-1:0] month_start(input logic [MonthW-1:0] mon);
    logic [MdayW-1:0] res;
    unique case (mon)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* design/civil_time_to_epoch_seconds_top.sv */
// Broken-down UTC time to Unix epoch seconds (Gregorian calendar).
// Depends on ctes_pkg and ctes_pipe_ctrl.
//
// Converts time words through a seven-stage pipeline: an accepted word passes
// through stage registers s1 to s7 and is shown on the output from s7.
// Throughput is one word per cycle while the output side is ready; it is set
// by the per-stage load enables, which let a stage take a new word whenever its
// current word moves on, so empty stages fill up even while a finished result
// waits on the output. A year before 1970 or a month above 11 raises
// bad_input_o and gives epoch_seconds_o of zero. The day is not checked
// against the month length; day 0 is the day before the first, and on
// 1970-01-01 it wraps modulo 2^38. Only the valid bits reset; no configuration.
module civil_time_to_epoch_seconds_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ctes_pkg::YearOffW-1:0]   year_offset_i,
  input  logic [ctes_pkg::MonthW-1:0]     month_i,
  input  logic [ctes_pkg::DayW-1:0]       day_of_month_i,
  input  logic [ctes_pkg::HourW-1:0]      hour_i,
  input  logic [ctes_pkg::MinuteW-1:0]    minute_i,
  input  logic [ctes_pkg::SecondW-1:0]    second_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ctes_pkg::SecsW-1:0]      epoch_seconds_o,
  output logic                            bad_input_o
);

  ctes_pkg::pipe_ctrl_t ctrl;

  ctes_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  assign in_ready_o  = ctrl.en[0];
  assign out_valid_o = ctrl.valid[ctes_pkg::NumStages-1];

  // ---------------------------------------------------------------- stage 1
  logic [ctes_pkg::YearW-1:0]   s1_year_q, s1_year_d, s1_prev_q, s1_prev_d;
  logic                         s1_bad_q, s1_bad_d;
  logic [ctes_pkg::MonthW-1:0]  s1_mon_q;
  logic [ctes_pkg::DayW-1:0]    s1_day_q;
  logic [ctes_pkg::HourW-1:0]   s1_hr_q;
  logic [ctes_pkg::MinuteW-1:0] s1_mn_q;
  logic [ctes_pkg::SecondW-1:0] s1_sc_q;

  // Form the calendar year and the year before it; flag bad words
  always_comb begin
    s1_year_d = ctes_pkg::YearW'(year_offset_i) + ctes_pkg::YearW'(ctes_pkg::YearBase);
    s1_prev_d = ctes_pkg::YearW'(year_offset_i) + ctes_pkg::YearW'(ctes_pkg::YearBase - 1);
    s1_bad_d  = (year_offset_i < ctes_pkg::YearOffW'(ctes_pkg::EpochYearOff)) ||
                (month_i > ctes_pkg::MonthW'(ctes_pkg::MonthsPerYear - 1));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      s1_year_q <= s1_year_d;
      s1_prev_q <= s1_prev_d;
      s1_bad_q  <= s1_bad_d;
      s1_mon_q  <= month_i;
      s1_day_q  <= day_of_month_i;
      s1_hr_q   <= hour_i;
      s1_mn_q   <= minute_i;
      s1_sc_q   <= second_i;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [ctes_pkg::ProdW-1:0]    s2_prod_p, s2_prod_y;
  logic [ctes_pkg::CentW-1:0]    s2_cp_q, s2_cy_q;
  logic [ctes_pkg::RelYearW-1:0] s2_rel_q, s2_rel_d;
  logic [ctes_pkg::Quart4W-1:0]  s2_p4_q;
  logic [ctes_pkg::YearW-1:0]    s2_year_q;
  logic                          s2_bad_q;
  logic [ctes_pkg::MonthW-1:0]   s2_mon_q;
  logic [ctes_pkg::DayW-1:0]     s2_day_q;
  logic [ctes_pkg::HourW-1:0]    s2_hr_q;
  logic [ctes_pkg::MinuteW-1:0]  s2_mn_q;
  logic [ctes_pkg::SecondW-1:0]  s2_sc_q;

  // Divide year and previous year by 100 through the reciprocal
  always_comb begin
    s2_prod_p = ctes_pkg::ProdW'(s1_prev_q) *
                ctes_pkg::ProdW'(ctes_pkg::Recip100);
    s2_prod_y = ctes_pkg::ProdW'(s1_year_q) *
                ctes_pkg::ProdW'(ctes_pkg::Recip100);
    s2_rel_d  = ctes_pkg::RelYearW'(s1_year_q - ctes_pkg::YearW'(ctes_pkg::EpochYear));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[1]) begin
      s2_cp_q   <= s2_prod_p[ctes_pkg::RecipShift +: ctes_pkg::CentW];
      s2_cy_q   <= s2_prod_y[ctes_pkg::RecipShift +: ctes_pkg::CentW];
      s2_rel_q  <= s2_rel_d;
      s2_p4_q   <= s1_prev_q[ctes_pkg::YearW-1:2];
      s2_year_q <= s1_year_q;
      s2_bad_q  <= s1_bad_q;
      s2_mon_q  <= s1_mon_q;
      s2_day_q  <= s1_day_q;
      s2_hr_q   <= s1_hr_q;
      s2_mn_q   <= s1_mn_q;
      s2_sc_q   <= s1_sc_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [ctes_pkg::YearDayW-1:0] s3_y365_q, s3_y365_d;
  logic [ctes_pkg::LeapW-1:0]    s3_leap_q, s3_leap_d;
  logic [ctes_pkg::MdayW-1:0]    s3_mday_q, s3_mday_d;
  logic [ctes_pkg::YearW-1:0]    s3_cent100;
  logic                          s3_is_leap;
  logic                          s3_bad_q;
  logic [ctes_pkg::HourW-1:0]    s3_hr_q;
  logic [ctes_pkg::MinuteW-1:0]  s3_mn_q;
  logic [ctes_pkg::SecondW-1:0]  s3_sc_q;

  // Whole-year days, leap days since the epoch, day within the year
  always_comb begin
    s3_y365_d  = ctes_pkg::YearDayW'(s2_rel_q) *
                 ctes_pkg::YearDayW'(ctes_pkg::DaysPerYear);
    s3_leap_d  = ctes_pkg::LeapW'(s2_p4_q) - ctes_pkg::LeapW'(s2_cp_q) +
                 ctes_pkg::LeapW'(s2_cp_q[ctes_pkg::CentW-1:2]) -
                 ctes_pkg::LeapW'(ctes_pkg::EpochLeaps);
    s3_cent100 = ctes_pkg::YearW'(s2_cy_q) * ctes_pkg::YearW'(100);
    s3_is_leap = (s2_year_q[1:0] == 2'b00) &&
                 ((s2_year_q != s3_cent100) || (s2_cy_q[1:0] == 2'b00));
    s3_mday_d  = ctes_pkg::month_start(s2_mon_q) + ctes_pkg::MdayW'(s2_day_q) +
                 ctes_pkg::MdayW'((s2_mon_q > ctes_pkg::MonthW'(ctes_pkg::FebIndex))
                                  && s3_is_leap);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[2]) begin
      s3_y365_q <= s3_y365_d;
      s3_leap_q <= s3_leap_d;
      s3_mday_q <= s3_mday_d;
      s3_bad_q  <= s2_bad_q;
      s3_hr_q   <= s2_hr_q;
      s3_mn_q   <= s2_mn_q;
      s3_sc_q   <= s2_sc_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [ctes_pkg::SecsW-1:0]   s4_days_q, s4_days_d;
  logic                         s4_bad_q;
  logic [ctes_pkg::HourW-1:0]   s4_hr_q;
  logic [ctes_pkg::MinuteW-1:0] s4_mn_q;
  logic [ctes_pkg::SecondW-1:0] s4_sc_q;

  // Sum the day count; the day of month counts from one
  always_comb begin
    s4_days_d = ctes_pkg::SecsW'(s3_y365_q) + ctes_pkg::SecsW'(s3_leap_q) +
                ctes_pkg::SecsW'(s3_mday_q) - ctes_pkg::SecsW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[3]) begin
      s4_days_q <= s4_days_d;
      s4_bad_q  <= s3_bad_q;
      s4_hr_q   <= s3_hr_q;
      s4_mn_q   <= s3_mn_q;
      s4_sc_q   <= s3_sc_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [ctes_pkg::SecsW-1:0]   s5_hrs_q, s5_hrs_d;
  logic                         s5_bad_q;
  logic [ctes_pkg::MinuteW-1:0] s5_mn_q;
  logic [ctes_pkg::SecondW-1:0] s5_sc_q;

  // Scale days to hours
  always_comb begin
    s5_hrs_d = s4_days_q * ctes_pkg::SecsW'(ctes_pkg::HoursPerDay) +
               ctes_pkg::SecsW'(s4_hr_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[4]) begin
      s5_hrs_q <= s5_hrs_d;
      s5_bad_q <= s4_bad_q;
      s5_mn_q  <= s4_mn_q;
      s5_sc_q  <= s4_sc_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [ctes_pkg::SecsW-1:0]   s6_mins_q, s6_mins_d;
  logic                         s6_bad_q;
  logic [ctes_pkg::SecondW-1:0] s6_sc_q;

  // Scale hours to minutes
  always_comb begin
    s6_mins_d = s5_hrs_q * ctes_pkg::SecsW'(ctes_pkg::SixtyPer) +
                ctes_pkg::SecsW'(s5_mn_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[5]) begin
      s6_mins_q <= s6_mins_d;
      s6_bad_q  <= s5_bad_q;
      s6_sc_q   <= s5_sc_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic [ctes_pkg::SecsW-1:0] s7_secs_q, s7_secs_d;
  logic                       s7_bad_q;

  // Scale minutes to seconds; force zero on a bad word
  always_comb begin
    s7_secs_d = s6_mins_q * ctes_pkg::SecsW'(ctes_pkg::SixtyPer) +
                ctes_pkg::SecsW'(s6_sc_q);
    if (s6_bad_q) begin
      s7_secs_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[6]) begin
      s7_secs_q <= s7_secs_d;
      s7_bad_q  <= s6_bad_q;
    end
  end

  assign epoch_seconds_o = s7_secs_q;
  assign bad_input_o     = s7_bad_q;

endmodule

/* design/ctes_pipe_ctrl.sv */
// Valid chain and per-stage load enables for the conversion pipeline.
// Depends on ctes_pkg (NumStages, pipe_ctrl_t).
module ctes_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output ctes_pkg::pipe_ctrl_t ctrl_o
);

  logic [ctes_pkg::NumStages-1:0] valid_q, valid_d;
  logic [ctes_pkg::NumStages-1:0] en;

  // A stage loads when it is empty or its word moves on; bubbles close up
  always_comb begin
    en[ctes_pkg::NumStages-1] = !valid_q[ctes_pkg::NumStages-1] || out_ready_i;
    for (int k = ctes_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Advance the valid bits alongside the data
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < ctes_pkg::NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.en    = en;
  assign ctrl_o.valid = valid_q;

endmodule

/* verif/tb_civil_time_to_epoch_seconds_top.sv */
// Self-checking testbench for civil_time_to_epoch_seconds_top.
// Depends on ctes_pkg and the converter RTL. Directed, then random, time words are
// checked against set values or a calendar predictor under random valid/ready idling.
`timescale 1ns / 1ps

module tb_civil_time_to_epoch_seconds_top;

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned ResetLen   = 12;
  localparam int unsigned NumRandom  = 1000;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned CycleLimit = 200000;

  // One converted result
  typedef struct packed {
    logic [ctes_pkg::SecsW-1:0] secs;
    logic                       bad;
  } epoch_word_t;

  // One stimulus row; fixed marks a hand-written expectation
  typedef struct packed {
    logic [ctes_pkg::YearOffW-1:0] yoff;
    logic [ctes_pkg::MonthW-1:0]   mon;
    logic [ctes_pkg::DayW-1:0]     mday;
    logic [ctes_pkg::HourW-1:0]    hr;
    logic [ctes_pkg::MinuteW-1:0]  mn;
    logic [ctes_pkg::SecondW-1:0]  sc;
    logic                          fixed;
    epoch_word_t                   want;
  } civil_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [ctes_pkg::YearOffW-1:0] year_offset_i = '0;
  logic [ctes_pkg::MonthW-1:0]   month_i = '0;
  logic [ctes_pkg::DayW-1:0]     day_of_month_i = '0;
  logic [ctes_pkg::HourW-1:0]    hour_i = '0;
  logic [ctes_pkg::MinuteW-1:0]  minute_i = '0;
  logic [ctes_pkg::SecondW-1:0]  second_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [ctes_pkg::SecsW-1:0]    epoch_seconds_o;
  logic                          bad_input_o;

  // Expectation attached to the word currently offered
  logic                word_fixed = 1'b0;
  epoch_word_t         word_want = '0;

  epoch_word_t         epoch_due_q[$];
  civil_row_t          directed_rows[$];
  int unsigned         n_checked = 0;
  int unsigned         n_flagged = 0;
  int unsigned         n_fail = 0;
  int unsigned         cycle_cnt = 0;
  logic                no_idle = 1'b0;

  civil_time_to_epoch_seconds_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .year_offset_i  (year_offset_i),
    .month_i        (month_i),
    .day_of_month_i (day_of_month_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .second_i       (second_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .epoch_seconds_o(epoch_seconds_o),
    .bad_input_o    (bad_input_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Leap days in the years before year y
  function automatic longint unsigned leap_days(input longint unsigned y);
    longint unsigned p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  // Seconds since the epoch for one broken-down time, flag on early year or bad month
  function automatic epoch_word_t civil_to_epoch(
      input logic [ctes_pkg::YearOffW-1:0] yoff,
      input logic [ctes_pkg::MonthW-1:0] mon,
      input logic [ctes_pkg::DayW-1:0] mday,
      input logic [ctes_pkg::HourW-1:0] hr,
      input logic [ctes_pkg::MinuteW-1:0] mn,
      input logic [ctes_pkg::SecondW-1:0] sc);
    epoch_word_t     res;
    longint unsigned yr, days, secs, days_prior;
    res.secs = '0;
    res.bad  = 1'b1;
    if (yoff < ctes_pkg::EpochYearOff || mon >= ctes_pkg::MonthsPerYear) return res;
    yr = longint'(yoff) + ctes_pkg::YearBase;
    case (mon)
      4'd0:    days_prior = 0;
      4'd1:    days_prior = 31;
      4'd2:    days_prior = 59;
      4'd3:    days_prior = 90;
      4'd4:    days_prior = 120;
      4'd5:    days_prior = 151;
      4'd6:    days_prior = 181;
      4'd7:    days_prior = 212;
      4'd8:    days_prior = 243;
      4'd9:    days_prior = 273;
      4'd10:   days_prior = 304;
      default: days_prior = 334;
    endcase
    days = ctes_pkg::DaysPerYear * (yr - ctes_pkg::EpochYear) + leap_days(yr) -
           leap_days(ctes_pkg::EpochYear) + days_prior;
    // add the leap day once February is over
    if (mon > ctes_pkg::FebIndex && yr % 4 == 0 && (yr % 100 != 0 || yr % 400 == 0))
      days = days + 1;
    days = days + longint'(mday) - 1;
    secs = ((days * ctes_pkg::HoursPerDay + hr) * ctes_pkg::SixtyPer + mn) *
           ctes_pkg::SixtyPer + sc;
    res.secs = secs[ctes_pkg::SecsW-1:0];
    res.bad  = 1'b0;
    return res;
  endfunction

  function automatic civil_row_t mk_row(input int yoff, input int mon, input int mday,
                                        input int hr, input int mn, input int sc,
                                        input bit fixed, input longint unsigned secs,
                                        input bit bad);
    civil_row_t r;
    r.yoff      = ctes_pkg::YearOffW'(yoff);
    r.mon       = ctes_pkg::MonthW'(mon);
    r.mday      = ctes_pkg::DayW'(mday);
    r.hr        = ctes_pkg::HourW'(hr);
    r.mn        = ctes_pkg::MinuteW'(mn);
    r.sc        = ctes_pkg::SecondW'(sc);
    r.fixed     = fixed;
    r.want.secs = secs[ctes_pkg::SecsW-1:0];
    r.want.bad  = bad;
    return r;
  endfunction

  // Mostly well-formed times, with out-of-range fields mixed in
  function automatic civil_row_t random_row();
    civil_row_t r;
    int unsigned pick;
    r = '0;
    pick = $urandom_range(0, 9);
    if (pick < 2)
      r.yoff = ctes_pkg::YearOffW'($urandom_range(0, (1 << ctes_pkg::YearOffW) - 1));
    else if (pick < 4)
      r.yoff = ctes_pkg::YearOffW'(100 * $urandom_range(1, 80) + $urandom_range(0, 4));
    else if (pick < 5)
      r.yoff = ctes_pkg::YearOffW'($urandom_range(ctes_pkg::EpochYearOff - 2,
                                                  ctes_pkg::EpochYearOff + 3));
    else r.yoff = ctes_pkg::YearOffW'($urandom_range(ctes_pkg::EpochYearOff, 8099));
    r.mon  = ctes_pkg::MonthW'(($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) :
                                                             $urandom_range(0, 11));
    r.mday = ctes_pkg::DayW'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 31));
    r.hr   = ctes_pkg::HourW'(($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) :
                                                            $urandom_range(0, 23));
    r.mn   = ctes_pkg::MinuteW'(($urandom_range(0, 9) == 0) ? $urandom_range(60, 63) :
                                                              $urandom_range(0, 59));
    r.sc   = ctes_pkg::SecondW'(($urandom_range(0, 9) == 0) ? $urandom_range(61, 63) :
                                                              $urandom_range(0, 60));
    return r;
  endfunction

  // Offer one word after a random gap and hold it until it is taken
  task automatic send_word(input civil_row_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    year_offset_i  <= r.yoff;
    month_i        <= r.mon;
    day_of_month_i <= r.mday;
    hour_i         <= r.hr;
    minute_i       <= r.mn;
    second_i       <= r.sc;
    word_fixed     <= r.fixed;
    word_want      <= r.want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Record accepted words and compare results against the oldest expectation
  always @(posedge clk_i) begin : check_results
    epoch_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (word_fixed) epoch_due_q.push_back(word_want);
        else epoch_due_q.push_back(civil_to_epoch(year_offset_i, month_i, day_of_month_i,
                                                  hour_i, minute_i, second_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (epoch_due_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with nothing expected, got %0d bad %0d",
                   $time, epoch_seconds_o, bad_input_o);
        end else begin
          want = epoch_due_q.pop_front();
          n_checked++;
          if (want.bad) n_flagged++;
          if (epoch_seconds_o !== want.secs) begin
            n_fail++;
            $display("%0t: epoch_seconds expected %0d, got %0d",
                     $time, want.secs, epoch_seconds_o);
          end
          if (bad_input_o !== want.bad) begin
            n_fail++;
            $display("%0t: bad_input expected %0d, got %0d", $time, want.bad, bad_input_o);
          end
        end
      end
    end
  end

  // Stall the output side by a random count per result
  initial begin : drain_results
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               epoch_due_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : drive_words
    // epoch, first second, first day, turn of 2000
    directed_rows.push_back(mk_row(70, 0, 1, 0, 0, 0, 1, 0, 0));
    directed_rows.push_back(mk_row(70, 0, 1, 0, 0, 1, 1, 1, 0));
    directed_rows.push_back(mk_row(70, 0, 2, 0, 0, 0, 1, 86400, 0));
    directed_rows.push_back(mk_row(100, 0, 1, 0, 0, 0, 1, 946684800, 0));
    // early year, bad month, all-zero and all-ones words
    directed_rows.push_back(mk_row(69, 0, 1, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(70, 12, 1, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(8191, 15, 31, 31, 63, 63, 1, 0, 1));
    // day zero on the epoch day wraps below zero
    directed_rows.push_back(mk_row(70, 0, 0, 0, 0, 0, 1,
                                   (64'd1 << ctes_pkg::SecsW) - 86400, 0));
    directed_rows.push_back(mk_row(70, 0, 0, 23, 59, 59, 1,
                                   (64'd1 << ctes_pkg::SecsW) - 1, 0));
    // widest fields and the top of the range
    directed_rows.push_back(mk_row(8191, 11, 31, 31, 63, 63, 0, 0, 0));
    directed_rows.push_back(mk_row(8099, 11, 31, 23, 59, 60, 0, 0, 0));
    // leap day handling across century rules
    directed_rows.push_back(mk_row(100, 1, 29, 12, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(100, 2, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(200, 2, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(500, 2, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(124, 11, 31, 23, 59, 60, 0, 0, 0));
    // day past the end of February runs on into March
    directed_rows.push_back(mk_row(71, 1, 31, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(96, 5, 15, 8, 30, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(4096, 6, 16, 16, 32, 32, 0, 0, 0));

    // hold reset, then release on an edge
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // hold off until the pipe is empty before the random part
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (epoch_due_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      // run full rate in two stretches, drain once midway
      no_idle <= (n >= 200 && n < 300) || (n >= 700 && n < 800);
      if (n == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (epoch_due_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      send_word(random_row());
    end

    // wait for the last results and a little longer
    in_valid_i <= 1'b0;
    no_idle    <= 1'b0;
    @(posedge clk_i);
    while (epoch_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("checked %0d conversions (%0d flagged as bad input), %0d directed rows",
             n_checked, n_flagged, directed_rows.size());
    $display("random idling on both sides, with full-rate stretches and a mid-run drain");
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* civil_time_to_epoch_seconds_top.f */
design/ctes_pkg.sv
design/ctes_pipe_ctrl.sv
design/civil_time_to_epoch_seconds_top.sv
verif/tb_civil_time_to_epoch_seconds_top.sv
